// ===== rtl/wemd_pkg.sv =====
// ----------------------------------------------------------------------------
// wemd_pkg
// Shared widths, limits and the stored event layout of the 1-D weighted
// earth mover distance block.
// ----------------------------------------------------------------------------
package wemd_pkg;

   localparam int POS_W  = 32;
   localparam int WGT_W  = 24;
   localparam int MAS_W  = 25;
   localparam int DIST_W = 63;
   localparam int ECNT_W = 9;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   typedef logic signed [POS_W-1:0] pos_type;
   typedef logic signed [MAS_W-1:0] mass_type;

   // one stored event: position and signed mass
   typedef struct packed {
      pos_type  pos;
      mass_type mass;
   } entry_type;

   localparam int ENT_W = $bits(entry_type);

endpackage

// ===== rtl/wemd_ram.sv =====
// ----------------------------------------------------------------------------
// wemd_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module wemd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

// ===== rtl/weighted_emd_1d.sv =====
// ----------------------------------------------------------------------------
// weighted_emd_1d
// One-dimensional weighted earth mover distance over a tagged sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one sample per beat (value Q16.16, weight Q8.16, a tag for
//   the second distribution, and a last marker). Loading takes one cycle per
//   sample. Samples past MAX_EVENTS are dropped and flagged.
//   On the last beat the block sorts the held events with a bottom-up merge
//   sort between two RAM banks, reading then writing each event in each of
//   ceil(log2 n) passes, then sweeps them: each event is read and evaluated,
//   and when a gap product is needed it runs MUL0, MUL1, MUL2 and CHK (a 32 x
//   (MASS/2) multiplier used twice per event).
//   rsp_ channel: one beat per set, held until rsp_ready; req_ready stays low
//   from the last beat until that result beat is taken, so a stalled receiver
//   simply holds the block.
//   Reset empties the set; no clearing pass is run over the RAMs.
// ----------------------------------------------------------------------------
module weighted_emd_1d #(
   parameter int MAX_EVENTS = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  wemd_pkg::pos_type              req_sample_value,
   input  logic [wemd_pkg::WGT_W-1:0]     req_sample_weight,
   input  logic                           req_from_second,
   input  logic                           req_last_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [wemd_pkg::DIST_W-1:0]    rsp_distance,
   output logic [wemd_pkg::ECNT_W-1:0]    rsp_event_count,
   output logic                           rsp_overflowed
);
   import wemd_pkg::*;

   localparam int ADDR_W  = $clog2(MAX_EVENTS);
   localparam int CNT_W   = $clog2(MAX_EVENTS + 1);
   localparam int IX_W    = CNT_W + 2;
   localparam int MASS_W  = 26 + ADDR_W;
   localparam int SPLIT_W = (MASS_W + 1) / 2;
   localparam int HI_W    = MASS_W - SPLIT_W;
   localparam int PROD_W  = POS_W + SPLIT_W;
   localparam int TOT_W   = 66 + ADDR_W;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MSETUP = 4'd1;
   localparam logic [3:0] ST_MRD    = 4'd2;
   localparam logic [3:0] ST_MWR    = 4'd3;
   localparam logic [3:0] ST_SRD    = 4'd4;
   localparam logic [3:0] ST_SEV    = 4'd5;
   localparam logic [3:0] ST_MUL0   = 4'd6;
   localparam logic [3:0] ST_MUL1   = 4'd7;
   localparam logic [3:0] ST_MUL2   = 4'd8;
   localparam logic [3:0] ST_CHK    = 4'd9;
   localparam logic [3:0] ST_DONE   = 4'd10;

   logic [3:0]               state_ff;
   logic [CNT_W-1:0]         count_ff;
   logic                     drop_ff;
   logic                     sel_ff;
   logic [IX_W-1:0]          w_ff, lo_ff, mid_ff, hi_ff, i_ff, j_ff, k_ff;
   logic signed [MASS_W-1:0] rm_ff;
   pos_type                  prev_ff;
   logic [POS_W-1:0]         gap_ff;
   logic [MASS_W-1:0]        mag_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [TOT_W-1:0]         tot_ff;
   logic                     sat_ff;

   logic                     accept, room, load_we, merge_we, take_a;
   logic [CNT_W-1:0]         n_last;
   logic [IX_W-1:0]          n_ix, mid_calc, hi_calc, lo_w, lo_2w, w_dbl, k_nx, i_nx;
   mass_type                 wmass, wmass_neg;
   entry_type                entry_in, a_ent, b_ent, merge_ent;
   entry_type                rd0a, rd0b, rd1a, rd1b;
   logic [ADDR_W-1:0]        wr_addr_0;
   logic [POS_W-1:0]         gap_calc;
   logic [MASS_W-1:0]        mag_calc;
   logic signed [MASS_W-1:0] mass_ext;
   logic [SPLIT_W-1:0]       mul_b;
   logic [PROD_W-1:0]        mul_p;
   logic [31:0]              cnt32;

   // handshake and load path
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign room      = (count_ff < CNT_W'(MAX_EVENTS));
   assign load_we   = accept && room;
   assign n_last    = room ? count_ff + CNT_W'(1) : count_ff;
   assign n_ix      = IX_W'(count_ff);
   assign wmass     = MAS_W'({1'b0, req_sample_weight});
   assign wmass_neg = -wmass;
   assign entry_in  = '{pos: req_sample_value, mass: req_from_second ? wmass_neg : wmass};

   // merge selection
   assign a_ent     = sel_ff ? rd1a : rd0a;
   assign b_ent     = sel_ff ? rd1b : rd0b;
   assign take_a    = (i_ff < mid_ff) && ((j_ff >= hi_ff) || (a_ent.pos <= b_ent.pos));
   assign merge_ent = take_a ? a_ent : b_ent;
   assign merge_we  = (state_ff == ST_MWR);
   assign k_nx      = k_ff + IX_W'(1);
   assign i_nx      = i_ff + IX_W'(1);
   assign w_dbl     = w_ff << 1;
   assign lo_w      = lo_ff + w_ff;
   assign lo_2w     = lo_ff + w_dbl;
   assign mid_calc  = (lo_w < n_ix) ? lo_w : n_ix;
   assign hi_calc   = (lo_2w < n_ix) ? lo_2w : n_ix;
   assign wr_addr_0 = load_we ? count_ff[ADDR_W-1:0] : k_ff[ADDR_W-1:0];

   // sweep terms
   assign gap_calc = (i_ff == '0) ? '0 : POS_W'(a_ent.pos - prev_ff);
   assign mag_calc = rm_ff[MASS_W-1] ? MASS_W'(-rm_ff) : MASS_W'(rm_ff);
   assign mass_ext = {{(MASS_W-MAS_W){a_ent.mass[MAS_W-1]}}, a_ent.mass};

   // shared multiplier: low half of the mass first, then the high half
   assign mul_b = (state_ff == ST_MUL0) ? mag_ff[SPLIT_W-1:0]
                                        : SPLIT_W'(mag_ff[MASS_W-1 -: HI_W]);
   assign mul_p = PROD_W'(gap_ff) * PROD_W'(mul_b);

   // event banks, ping-pong between merge passes
   wemd_ram #(.WIDTH(ENT_W), .DEPTH(MAX_EVENTS)) u_bank0 (
      .clock     (clock),
      .wr_en     (load_we || (merge_we && sel_ff)),
      .wr_addr   (wr_addr_0),
      .wr_data   (load_we ? entry_in : merge_ent),
      .rd_addr_a (i_ff[ADDR_W-1:0]),
      .rd_data_a (rd0a),
      .rd_addr_b (j_ff[ADDR_W-1:0]),
      .rd_data_b (rd0b)
   );

   wemd_ram #(.WIDTH(ENT_W), .DEPTH(MAX_EVENTS)) u_bank1 (
      .clock     (clock),
      .wr_en     (merge_we && !sel_ff),
      .wr_addr   (k_ff[ADDR_W-1:0]),
      .wr_data   (merge_ent),
      .rd_addr_a (i_ff[ADDR_W-1:0]),
      .rd_data_a (rd1a),
      .rd_addr_b (j_ff[ADDR_W-1:0]),
      .rd_data_b (rd1b)
   );

   // sequencer: load, merge passes, sweep, result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         drop_ff  <= 1'b0;
         sat_ff   <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (room) begin
                     count_ff <= count_ff + CNT_W'(1);
                  end else begin
                     drop_ff <= 1'b1;
                  end
                  if (req_last_sample) begin
                     w_ff   <= IX_W'(1);
                     lo_ff  <= '0;
                     i_ff   <= '0;
                     sel_ff <= 1'b0;
                     rm_ff  <= '0;
                     tot_ff <= '0;
                     sat_ff <= 1'b0;
                     if (n_last > CNT_W'(1)) begin
                        state_ff <= ST_MSETUP;
                     end else if (n_last == CNT_W'(1)) begin
                        state_ff <= ST_SRD;
                     end else begin
                        state_ff <= ST_DONE;
                     end
                  end
               end
            end
            ST_MSETUP: begin
               mid_ff   <= mid_calc;
               hi_ff    <= hi_calc;
               i_ff     <= lo_ff;
               j_ff     <= mid_calc;
               k_ff     <= lo_ff;
               state_ff <= ST_MRD;
            end
            ST_MRD: begin
               state_ff <= ST_MWR;
            end
            ST_MWR: begin
               k_ff <= k_nx;
               if (k_nx != hi_ff) begin
                  if (take_a) begin
                     i_ff <= i_nx;
                  end else begin
                     j_ff <= j_ff + IX_W'(1);
                  end
                  state_ff <= ST_MRD;
               end else if (hi_ff != n_ix) begin
                  lo_ff    <= hi_ff;
                  state_ff <= ST_MSETUP;
               end else begin
                  sel_ff <= !sel_ff;
                  w_ff   <= w_dbl;
                  lo_ff  <= '0;
                  if (w_dbl >= n_ix) begin
                     i_ff     <= '0;
                     state_ff <= ST_SRD;
                  end else begin
                     state_ff <= ST_MSETUP;
                  end
               end
            end
            ST_SRD: begin
               state_ff <= ST_SEV;
            end
            ST_SEV: begin
               gap_ff  <= gap_calc;
               mag_ff  <= mag_calc;
               rm_ff   <= rm_ff + mass_ext;
               prev_ff <= a_ent.pos;
               if (!sat_ff && gap_calc != '0 && mag_calc != '0) begin
                  state_ff <= ST_MUL0;
               end else begin
                  i_ff     <= i_nx;
                  state_ff <= (i_nx == n_ix) ? ST_DONE : ST_SRD;
               end
            end
            ST_MUL0: begin
               prod_ff  <= mul_p;
               state_ff <= ST_MUL1;
            end
            ST_MUL1: begin
               tot_ff   <= tot_ff + TOT_W'(prod_ff);
               prod_ff  <= mul_p;
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               tot_ff   <= tot_ff + (TOT_W'(prod_ff) << SPLIT_W);
               state_ff <= ST_CHK;
            end
            ST_CHK: begin
               if (tot_ff > TOT_W'(DIST_MAX)) begin
                  tot_ff <= TOT_W'(DIST_MAX);
                  sat_ff <= 1'b1;
               end
               i_ff     <= i_nx;
               state_ff <= (i_nx == n_ix) ? ST_DONE : ST_SRD;
            end
            ST_DONE: begin
               if (rsp_ready) begin
                  count_ff <= '0;
                  drop_ff  <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // result beat
   assign cnt32           = 32'(count_ff);
   assign rsp_valid       = (state_ff == ST_DONE);
   assign rsp_distance    = tot_ff[DIST_W-1:0];
   assign rsp_event_count = cnt32[ECNT_W-1:0];
   assign rsp_overflowed  = drop_ff || sat_ff;

   // checks
   a_ready_vs_valid: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while result pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_EVENTS))
      else $error("event count past capacity");

   a_merge_has_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MWR) |-> ((i_ff < mid_ff) || (j_ff < hi_ff)))
      else $error("merge step with both runs empty");

   a_sat_holds_max: assert property (@(posedge clock) disable iff (reset)
      (sat_ff && state_ff != ST_CHK) |-> (tot_ff == TOT_W'(DIST_MAX)))
      else $error("saturated sum not at maximum");

endmodule

// ===== bench/weighted_emd_1d_tb.sv =====
// ----------------------------------------------------------------------------
// weighted_emd_1d_tb
// Drives tagged sample sets into the 1-D weighted earth mover distance block,
// predicts each set's distance, event count and overflow flag, and checks
// every result beat against the prediction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_emd_1d_tb;
   import wemd_pkg::*;

   localparam int CAP       = 256;
   localparam int IDLE_STOP = 200000;
   localparam logic [63:0] SAT_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [DIST_W-1:0] distance;
      logic [ECNT_W-1:0] event_count;
      logic              overflowed;
   } emd_result_type;

   // set accumulator and expected results in order
   class emd_scoreboard;
      pos_type          set_pos[$];
      longint           set_mass[$];
      bit               set_dropped;
      emd_result_type   pending[$];
      int               errors;
      int               seen;

      function void note_sample(pos_type value, logic [WGT_W-1:0] weight,
                                logic second, logic last);
         longint         m;
         int             n;
         int             i;
         int             j;
         pos_type        tp;
         longint         tm;
         longint         run;
         logic [63:0]    total;
         logic [63:0]    gap;
         logic [63:0]    mag;
         bit             sat;
         emd_result_type r;
         m = second ? -longint'(weight) : longint'(weight);
         if (set_pos.size() < CAP) begin
            set_pos.push_back(value);
            set_mass.push_back(m);
         end else begin
            set_dropped = 1;
         end
         if (!last) return;
         n = set_pos.size();
         // insertion sort by position
         for (i = 1; i < n; i++) begin
            tp = set_pos[i];
            tm = set_mass[i];
            j = i;
            while (j > 0 && set_pos[j-1] > tp) begin
               set_pos[j] = set_pos[j-1];
               set_mass[j] = set_mass[j-1];
               j--;
            end
            set_pos[j] = tp;
            set_mass[j] = tm;
         end
         // sweep: |running mass| times gap
         run = 0;
         total = 0;
         sat = 0;
         for (i = 0; i < n; i++) begin
            gap = (i == 0) ? 64'd0 : 64'(longint'(set_pos[i]) - longint'(set_pos[i-1]));
            mag = (run < 0) ? 64'(-run) : 64'(run);
            if (mag != 0 && gap != 0 && !sat) begin
               if (gap > (SAT_LIMIT - total) / mag) begin
                  total = SAT_LIMIT;
                  sat = 1;
               end else begin
                  total = total + gap * mag;
               end
            end
            run += set_mass[i];
         end
         r.distance = total[DIST_W-1:0];
         r.event_count = ECNT_W'(n);
         r.overflowed = set_dropped | sat;
         pending.push_back(r);
         set_pos.delete();
         set_mass.delete();
         set_dropped = 0;
      endfunction

      function void check_result(logic [DIST_W-1:0] d, logic [ECNT_W-1:0] c, logic o);
         emd_result_type e;
         seen++;
         if (pending.size() == 0) begin
            $error("result beat with no expectation: distance %0d", d);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (d !== e.distance) begin
            $error("distance: expected %0d, got %0d", e.distance, d);
            errors++;
         end
         if (c !== e.event_count) begin
            $error("event_count: expected %0d, got %0d", e.event_count, c);
            errors++;
         end
         if (o !== e.overflowed) begin
            $error("overflowed: expected %0d, got %0d", e.overflowed, o);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   pos_type            req_sample_value;
   logic [WGT_W-1:0]   req_sample_weight;
   logic               req_from_second;
   logic               req_last_sample;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [DIST_W-1:0]  rsp_distance;
   logic [ECNT_W-1:0]  rsp_event_count;
   logic               rsp_overflowed;

   emd_scoreboard sb;
   bit            calm;
   bit            hold_rsp;
   int            idle_cycles;
   int            beats_in;

   weighted_emd_1d #(.MAX_EVENTS(CAP)) dut (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_STOP) begin
         $display("timeout after %0d idle cycles", IDLE_STOP);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: check accepted beats
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_distance, rsp_event_count, rsp_overflowed);
   end

   // receiver stalls in random bursts, plus one long hold-off
   initial begin
      int k;
      rsp_ready = 0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            for (k = 0; k < 3000; k++) @(posedge clock);
            hold_rsp = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_ready <= 1;
            @(posedge clock);
         end
      end
   end

   // one sample beat, with an optional random gap first
   task automatic send_sample(pos_type v, logic [WGT_W-1:0] w, logic s, logic l);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1;
      req_sample_value <= v;
      req_sample_weight <= w;
      req_from_second <= s;
      req_last_sample <= l;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_sample(v, w, s, l);
      beats_in++;
   endtask

   function automatic pos_type rand_pos(int mode);
      case (mode)
         0: return pos_type'($urandom);
         1: return pos_type'($urandom_range(0, 64)) - 32;
         default: return pos_type'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      endcase
   endfunction

   function automatic logic [WGT_W-1:0] rand_weight();
      case ($urandom_range(0, 3))
         0: return '1;
         1: return WGT_W'($urandom_range(0, 3));
         default: return WGT_W'($urandom);
      endcase
   endfunction

   // a set of n samples with random content
   task automatic send_set(int n, int mode);
      int i;
      for (i = 0; i < n; i++)
         send_sample(rand_pos(mode), rand_weight(), $urandom_range(0, 1), i == n - 1);
   endtask

   initial begin
      int i;
      int n;
      sb = new();
      calm = 0;
      hold_rsp = 0;
      idle_cycles = 0;
      beats_in = 0;
      reset = 1;
      req_valid = 0;
      req_sample_value = 0;
      req_sample_weight = 0;
      req_from_second = 0;
      req_last_sample = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: single event, extremes, ties, zero weights, alternating bits
      send_sample(32'sh7FFF_FFFF, '1, 0, 1);
      send_sample(32'sh8000_0000, '1, 0, 0);
      send_sample(32'sh7FFF_FFFF, '1, 1, 1);
      send_sample(32'sh8000_0000, '1, 0, 0);
      send_sample(32'sh7FFF_FFFF, '1, 0, 1);
      send_sample(5, 100, 0, 0);
      send_sample(5, 100, 1, 0);
      send_sample(5, 7, 0, 1);
      send_sample(-3, 0, 0, 0);
      send_sample(10, 0, 1, 1);
      send_sample(0, 24'h010000, 0, 0);
      send_sample(32'sh0001_0000, 24'h010000, 1, 1);
      send_sample(32'sh5555_5555, 24'hAAAAAA, 1, 0);
      send_sample(32'shAAAA_AAAA, 24'h555555, 0, 1);

      // long receiver hold-off; further sets wait behind the pending result
      hold_rsp = 1;
      for (i = 0; i < 6; i++) send_set($urandom_range(1, 5), 1);

      // overflow: more than the store holds, last three dropped
      send_set(CAP + 3, 1);

      // exactly full, one-sided heavy mass across the whole range: saturates
      for (i = 0; i < CAP - 1; i++) send_sample(32'sh8000_0000, '1, 0, 0);
      send_sample(32'sh7FFF_FFFF, '1, 0, 1);

      // random sets, mostly small
      while (beats_in < 600) begin
         if (beats_in > 540) calm = 1;
         n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         send_set(n, $urandom_range(0, 2));
      end
      req_valid <= 0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("run: %0d sample beats, %0d result beats, incl. single-event, tie,",
               beats_in, sb.seen);
      $display("     saturating, dropped-sample and full-store sets");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
